### hdl/etc_pkg.sv
// Package for the encoder threshold calibrator: phase codes, register
// indexes and register reset values. No dependencies.
package etc_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_CAL    = 3'd1,
        PH_VERIFY = 3'd2,
        PH_DONE   = 3'd3,
        PH_FAIL   = 3'd4
    } t_phase;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_CALIBRATE_MS  = 3'd0;
    localparam t_cfg_idx CFG_VERIFY_MS     = 3'd1;
    localparam t_cfg_idx CFG_EXPECTED_REVS = 3'd2;
    localparam t_cfg_idx CFG_DEAD_BAND     = 3'd3;
    localparam t_cfg_idx CFG_RUN_SPEED     = 3'd4;
    localparam t_cfg_idx CFG_CHECK_SPEED   = 3'd5;

    localparam logic [15:0] RST_CALIBRATE_MS  = 16'd800;
    localparam logic [15:0] RST_VERIFY_MS     = 16'd6600;
    localparam logic [7:0]  RST_EXPECTED_REVS = 8'd5;
    localparam logic [15:0] RST_DEAD_BAND     = 16'd3277;
    localparam logic [6:0]  RST_RUN_SPEED     = 7'd100;
    localparam logic [6:0]  RST_CHECK_SPEED   = 7'd25;

endpackage

### hdl/etc_bounds.sv
// Switching threshold arithmetic for one encoder channel.
// Depends on nothing beyond its own parameter.
module etc_bounds #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic [SAMPLE_BITS-1:0] i_high,
    input  logic [SAMPLE_BITS-1:0] i_low,
    input  logic [15:0]            i_dead_band,
    output logic [SAMPLE_BITS-1:0] o_upper,
    output logic [SAMPLE_BITS-1:0] o_lower
);

    localparam int PROD_BITS = SAMPLE_BITS + 16;

    logic [SAMPLE_BITS:0]   sum;
    logic [SAMPLE_BITS-1:0] mid;
    logic [SAMPLE_BITS-1:0] span_up;
    logic [SAMPLE_BITS-1:0] span_dn;
    logic [PROD_BITS-1:0]   prod_up;
    logic [PROD_BITS-1:0]   prod_dn;
    logic [PROD_BITS:0]     prod_dn_ceil;

    assign sum     = {1'b0, i_high} + {1'b0, i_low};
    assign mid     = sum[SAMPLE_BITS:1];
    assign span_up = i_high - mid;
    assign span_dn = mid - i_low;
    assign prod_up = PROD_BITS'(i_dead_band) * PROD_BITS'(span_up);
    assign prod_dn = PROD_BITS'(i_dead_band) * PROD_BITS'(span_dn);

    // The lower threshold moves away from the midpoint by the rounded-up product.
    assign prod_dn_ceil = {1'b0, prod_dn} + (PROD_BITS+1)'(17'h0FFFF);

    assign o_upper = mid + prod_up[PROD_BITS-1:16];
    assign o_lower = mid - prod_dn_ceil[SAMPLE_BITS+15:16];

endmodule

### hdl/encoder_threshold_calibrator_core.sv
// Channel       Direction  Handshake                Payload
// s (ticks)     in         i_s_tvalid/o_s_tready    i_s_tdata
// m (results)   out        o_m_tvalid/i_m_tready    o_m_tdata, o_m_tuser
// cfg           in         i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// Every tick beat gives exactly one result beat, held in an input register and then
// in a result register that drives the output. One tick is accepted every cycle while
// the output does not stall: the two registers each hold a beat, and the phase, window
// start and the min/max trackers are updated as a beat moves from the first to the second.
// A stall on the output fills the result register and then the input register.
// Reset (synchronous, active low) clears the phase, trackers and registers.
// Depends on etc_pkg and etc_bounds.
module encoder_threshold_calibrator_core
    import etc_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // now_ms[31:0], left_sample, right_sample, left_revs[7:0], right_revs[7:0], zero pad
    input  logic [((48+2*SAMPLE_BITS+7)/8)*8-1:0] i_s_tdata,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // phase[2:0], drive_speed[6:0], left_up_thr, left_dn_thr, right_up_thr,
    // right_dn_thr, count_reset, zero pad
    output logic [((12+4*SAMPLE_BITS+7)/8)*8-1:0] o_m_tdata,
    // drive_set, bounds_set
    output logic [1:0]                 o_m_tuser,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int SB      = SAMPLE_BITS;
    localparam int OUT_W   = ((12 + 4*SB + 7) / 8) * 8;
    localparam int OUT_USE = 11 + 4*SB;

    // Configuration registers
    logic [15:0] r_calibrate_ms;
    logic [15:0] r_verify_ms;
    logic [7:0]  r_expected_revs;
    logic [15:0] r_dead_band;
    logic [6:0]  r_run_speed;
    logic [6:0]  r_check_speed;

    // Input register
    logic          r_in_v;
    logic [31:0]   r_in_now;
    logic [SB-1:0] r_in_ls;
    logic [SB-1:0] r_in_rs;
    logic [7:0]    r_in_lr;
    logic [7:0]    r_in_rr;

    // Calibration state
    t_phase        r_phase;
    t_phase        n_phase;
    logic [31:0]   r_start;
    logic [31:0]   n_start;
    logic [SB-1:0] r_left_high,  n_left_high;
    logic [SB-1:0] r_left_low,   n_left_low;
    logic [SB-1:0] r_right_high, n_right_high;
    logic [SB-1:0] r_right_low,  n_right_low;

    // Result register
    logic          r_out_v;
    logic [OUT_W-1:0] r_out_data;
    logic [1:0]    r_out_user;

    logic          consume;
    logic          in_accept;
    logic [31:0]   elapsed;
    logic [SB-1:0] trk_lh, trk_ll, trk_rh, trk_rl;
    logic [SB-1:0] lu, ll, ru, rl;

    logic          res_drive_set;
    logic [6:0]    res_drive_speed;
    logic          res_bounds_set;
    logic          res_count_reset;
    logic [OUT_USE-1:0] res_data;

    assign consume     = r_in_v && (!r_out_v || i_m_tready);
    assign o_s_tready  = !r_in_v || consume;
    assign in_accept   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    assign elapsed = r_in_now - r_start;

    // Trackers including this beat's sample; bounds use these updated values.
    assign trk_lh = (r_in_ls > r_left_high)  ? r_in_ls : r_left_high;
    assign trk_ll = (r_in_ls < r_left_low)   ? r_in_ls : r_left_low;
    assign trk_rh = (r_in_rs > r_right_high) ? r_in_rs : r_right_high;
    assign trk_rl = (r_in_rs < r_right_low)  ? r_in_rs : r_right_low;

    etc_bounds #(.SAMPLE_BITS(SB)) u_left_bounds (
        .i_high      (trk_lh),
        .i_low       (trk_ll),
        .i_dead_band (r_dead_band),
        .o_upper     (lu),
        .o_lower     (ll)
    );

    etc_bounds #(.SAMPLE_BITS(SB)) u_right_bounds (
        .i_high      (trk_rh),
        .i_low       (trk_rl),
        .i_dead_band (r_dead_band),
        .o_upper     (ru),
        .o_lower     (rl)
    );

    // Next state
    always_comb begin
        n_phase      = r_phase;
        n_start      = r_start;
        n_left_high  = r_left_high;
        n_left_low   = r_left_low;
        n_right_high = r_right_high;
        n_right_low  = r_right_low;
        case (r_phase)
            PH_IDLE: begin
                n_phase = PH_CAL;
                n_start = r_in_now;
            end
            PH_CAL: begin
                n_left_high  = trk_lh;
                n_left_low   = trk_ll;
                n_right_high = trk_rh;
                n_right_low  = trk_rl;
                if (elapsed >= {16'd0, r_calibrate_ms}) begin
                    n_phase = PH_VERIFY;
                    n_start = r_in_now;
                end
            end
            PH_VERIFY: begin
                if (elapsed >= {16'd0, r_verify_ms}) begin
                    if (r_in_lr == r_expected_revs && r_in_rr == r_expected_revs) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Result fields
    always_comb begin
        res_drive_set   = 1'b0;
        res_drive_speed = 7'd0;
        res_bounds_set  = 1'b0;
        res_count_reset = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                res_drive_set   = 1'b1;
                res_drive_speed = r_run_speed;
            end
            PH_CAL: begin
                if (elapsed >= {16'd0, r_calibrate_ms}) begin
                    res_drive_set   = 1'b1;
                    res_drive_speed = r_check_speed;
                    res_bounds_set  = 1'b1;
                    res_count_reset = 1'b1;
                end
            end
            PH_VERIFY: begin
                if (elapsed >= {16'd0, r_verify_ms}) begin
                    res_drive_set   = 1'b1;
                    res_drive_speed = r_run_speed;
                    res_count_reset = 1'b1;
                end
            end
            default: begin
                res_drive_set = 1'b0;
            end
        endcase
    end

    // Thresholds read as zero on beats that do not issue them.
    assign res_data = {res_count_reset,
                       res_bounds_set ? rl : {SB{1'b0}},
                       res_bounds_set ? ru : {SB{1'b0}},
                       res_bounds_set ? ll : {SB{1'b0}},
                       res_bounds_set ? lu : {SB{1'b0}},
                       res_drive_speed,
                       n_phase};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calibrate_ms  <= RST_CALIBRATE_MS;
            r_verify_ms     <= RST_VERIFY_MS;
            r_expected_revs <= RST_EXPECTED_REVS;
            r_dead_band     <= RST_DEAD_BAND;
            r_run_speed     <= RST_RUN_SPEED;
            r_check_speed   <= RST_CHECK_SPEED;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CALIBRATE_MS:  r_calibrate_ms  <= i_cfg_data;
                CFG_VERIFY_MS:     r_verify_ms     <= i_cfg_data;
                CFG_EXPECTED_REVS: r_expected_revs <= i_cfg_data[7:0];
                CFG_DEAD_BAND:     r_dead_band     <= i_cfg_data;
                CFG_RUN_SPEED:     r_run_speed     <= i_cfg_data[6:0];
                CFG_CHECK_SPEED:   r_check_speed   <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (in_accept) begin
            r_in_v <= 1'b1;
        end else if (consume) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_now <= i_s_tdata[31:0];
            r_in_ls  <= i_s_tdata[32 +: SB];
            r_in_rs  <= i_s_tdata[32+SB +: SB];
            r_in_lr  <= i_s_tdata[32+2*SB +: 8];
            r_in_rr  <= i_s_tdata[40+2*SB +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_start      <= 32'd0;
            r_left_high  <= {SB{1'b0}};
            r_left_low   <= {SB{1'b1}};
            r_right_high <= {SB{1'b0}};
            r_right_low  <= {SB{1'b1}};
        end else if (consume) begin
            r_phase      <= n_phase;
            r_start      <= n_start;
            r_left_high  <= n_left_high;
            r_left_low   <= n_left_low;
            r_right_high <= n_right_high;
            r_right_low  <= n_right_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (consume) begin
            r_out_v <= 1'b1;
        end else if (i_m_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume) begin
            r_out_data <= OUT_W'(res_data);
            r_out_user <= {res_bounds_set, res_drive_set};
        end
    end

endmodule

### dv/testbench.sv
// Self-checking testbench for encoder_threshold_calibrator_core: drives tick beats and
// register writes, predicts every result beat and compares it field by field.
// Depends on etc_pkg and the calibrator RTL.
`timescale 1ns / 1ps

module testbench;
    import etc_pkg::*;

    localparam int SAMPLE_BITS    = 12;
    localparam int CAL_ITEMS      = 300;
    localparam int VERIFY_ITEMS   = 150;
    localparam int LATCHED_ITEMS  = 280;
    localparam int CALM_FROM      = 120;
    localparam int CALM_TO        = 260;
    localparam int HOLD_AT        = 130;
    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 3000;

    // Tick beat, now_ms in the lowest bits.
    typedef struct packed {
        logic [7:0]  right_revs;
        logic [7:0]  left_revs;
        logic [11:0] right_sample;
        logic [11:0] left_sample;
        logic [31:0] now_ms;
    } tick_t;

    // Result beat as carried on o_m_tdata, phase in the lowest bits.
    typedef struct packed {
        logic [4:0]  pad;
        logic        count_reset;
        logic [11:0] right_dn_thr;
        logic [11:0] right_up_thr;
        logic [11:0] left_dn_thr;
        logic [11:0] left_up_thr;
        logic [6:0]  drive_speed;
        t_phase      phase;
    } calib_result_t;

    typedef struct packed {
        logic          bounds_set;
        logic          drive_set;
        calib_result_t body;
    } calib_expected_t;

    class calib_scoreboard;
        logic [15:0]  cal_ms;
        logic [15:0]  ver_ms;
        logic [7:0]   want_revs;
        logic [15:0]  dead_band;
        logic [6:0]   run_spd;
        logic [6:0]   chk_spd;
        t_phase       phase;
        logic [31:0]  start;
        logic [11:0]  l_hi, l_lo, r_hi, r_lo;
        calib_expected_t outstanding[$];
        int           errors;
        int           beats;

        function new();
            cal_ms    = RST_CALIBRATE_MS;
            ver_ms    = RST_VERIFY_MS;
            want_revs = RST_EXPECTED_REVS;
            dead_band = RST_DEAD_BAND;
            run_spd   = RST_RUN_SPEED;
            chk_spd   = RST_CHECK_SPEED;
            phase     = PH_IDLE;
            start     = '0;
            l_hi      = '0;
            l_lo      = '1;
            r_hi      = '0;
            r_lo      = '1;
            errors    = 0;
            beats     = 0;
        endfunction

        function int pending();
            return outstanding.size();
        endfunction

        function void write_reg(t_cfg_idx idx, logic [15:0] val);
            case (idx)
                CFG_CALIBRATE_MS:  cal_ms = val;
                CFG_VERIFY_MS:     ver_ms = val;
                CFG_EXPECTED_REVS: want_revs = val[7:0];
                CFG_DEAD_BAND:     dead_band = val;
                CFG_RUN_SPEED:     run_spd = val[6:0];
                CFG_CHECK_SPEED:   chk_spd = val[6:0];
                default: ;
            endcase
        endfunction

        // Upper threshold rounds the dead-band offset down, lower rounds it up,
        // so both stay inside the observed range.
        function void thresholds(input logic [11:0] hi, input logic [11:0] lo,
                                 output logic [11:0] up, output logic [11:0] dn);
            logic [12:0] sum;
            logic [11:0] mid;
            logic [63:0] above, below;
            sum   = {1'b0, hi} + {1'b0, lo};
            mid   = sum[12:1];
            above = 64'(dead_band) * 64'(hi - mid);
            below = 64'(dead_band) * 64'(mid - lo);
            up    = 12'(64'(mid) + (above >> 16));
            dn    = 12'(64'(mid) - ((below + 64'hFFFF) >> 16));
        endfunction

        function void note_tick(tick_t t);
            calib_expected_t e;
            e = '0;
            case (phase)
                PH_IDLE: begin
                    start = t.now_ms;
                    phase = PH_CAL;
                    e.drive_set = 1'b1;
                    e.body.drive_speed = run_spd;
                end
                PH_CAL: begin
                    if (t.left_sample > l_hi) l_hi = t.left_sample;
                    if (t.left_sample < l_lo) l_lo = t.left_sample;
                    if (t.right_sample > r_hi) r_hi = t.right_sample;
                    if (t.right_sample < r_lo) r_lo = t.right_sample;
                    if (32'(t.now_ms - start) >= {16'd0, cal_ms}) begin
                        start = t.now_ms;
                        thresholds(l_hi, l_lo, e.body.left_up_thr, e.body.left_dn_thr);
                        thresholds(r_hi, r_lo, e.body.right_up_thr, e.body.right_dn_thr);
                        e.bounds_set = 1'b1;
                        phase = PH_VERIFY;
                        e.body.count_reset = 1'b1;
                        e.drive_set = 1'b1;
                        e.body.drive_speed = chk_spd;
                    end
                end
                PH_VERIFY: begin
                    if (32'(t.now_ms - start) >= {16'd0, ver_ms}) begin
                        phase = (t.left_revs == want_revs && t.right_revs == want_revs)
                                ? PH_DONE : PH_FAIL;
                        e.body.count_reset = 1'b1;
                        e.drive_set = 1'b1;
                        e.body.drive_speed = run_spd;
                    end
                end
                default: ;
            endcase
            e.body.phase = phase;
            outstanding.push_back(e);
        endfunction

        task report(string msg);
            $display("mismatch at result beat %0d: %s", beats, msg);
            errors++;
        endtask

        task compare(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s is %0h, should be %0h", name, got, want));
        endtask

        task check_result(logic [63:0] tdata, logic [1:0] tuser);
            calib_result_t   got;
            calib_expected_t want;
            got = tdata;
            if (outstanding.size() == 0) begin
                report("result beat with no tick outstanding");
                return;
            end
            want = outstanding.pop_front();
            compare("phase", got.phase, want.body.phase);
            compare("drive_set", tuser[0], want.drive_set);
            compare("drive_speed", got.drive_speed, want.body.drive_speed);
            compare("bounds_set", tuser[1], want.bounds_set);
            compare("left_up_thr", got.left_up_thr, want.body.left_up_thr);
            compare("left_dn_thr", got.left_dn_thr, want.body.left_dn_thr);
            compare("right_up_thr", got.right_up_thr, want.body.right_up_thr);
            compare("right_dn_thr", got.right_dn_thr, want.body.right_dn_thr);
            compare("count_reset", got.count_reset, want.body.count_reset);
            beats++;
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [71:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index = CFG_CALIBRATE_MS;
    logic [15:0] i_cfg_data = '0;

    logic        calm = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;
    int          idle_cycles = 0;
    int          sent = 0;

    calib_scoreboard sb = new();

    always #5 i_clk = ~i_clk;

    encoder_threshold_calibrator_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Result side: random back-pressure, one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tdata, o_m_tuser);
            if (hold_left != 0) begin
                i_m_tready <= 1'b0;
                hold_left  <= hold_left - 1;
            end else if (hold_req && !hold_done) begin
                i_m_tready <= 1'b0;
                hold_left  <= HOLD_CYCLES;
                hold_done  <= 1'b1;
            end else if (calm) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= ($urandom_range(99) >= 27);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_tick(input logic [31:0] now, input logic [11:0] ls,
                             input logic [11:0] rs, input logic [7:0] lr,
                             input logic [7:0] rr);
        tick_t t;
        bit    quiet;
        t.now_ms       = now;
        t.left_sample  = ls;
        t.right_sample = rs;
        t.left_revs    = lr;
        t.right_revs   = rr;
        quiet = (sent >= CALM_FROM && sent < CALM_TO);
        calm <= quiet;
        if (sent == HOLD_AT)
            hold_req <= 1'b1;
        if (!quiet && $urandom_range(99) < 27) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= t;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_tick(t);
        sent++;
    endtask

    // Pause the tick stream until every outstanding result beat has arrived.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Leaves i_cfg_valid high so that writes can follow back to back;
    // cfg_idle lowers it after the last one.
    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic cfg_idle();
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] reg_value(t_cfg_idx idx);
        case (idx)
            CFG_RUN_SPEED, CFG_CHECK_SPEED: begin
                case ($urandom_range(4))
                    0: return 16'd0;
                    1: return 16'd100;
                    2: return 16'd127;
                    3: return 16'($urandom_range(100));
                    default: return 16'($urandom());
                endcase
            end
            CFG_EXPECTED_REVS: begin
                case ($urandom_range(3))
                    0: return 16'd0;
                    1: return 16'd255;
                    2: return 16'($urandom_range(255));
                    default: return 16'($urandom());
                endcase
            end
            default: begin
                case ($urandom_range(3))
                    0: return 16'd0;
                    1: return 16'hFFFF;
                    2: return 16'd1;
                    default: return 16'($urandom());
                endcase
            end
        endcase
    endfunction

    // Sample drawn from a band around a centre, clipped to the ADC range.
    function automatic logic [11:0] band_sample(int centre, int spread);
        int v;
        v = centre + int'($urandom_range(2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return 12'(v);
    endfunction

    initial begin
        logic [31:0] now;
        int          l_centre, r_centre, l_spread, r_spread;
        logic [11:0] corner_l[8];
        logic [11:0] corner_r[8];
        logic [7:0]  lr, rr;
        t_cfg_idx    mid_regs[4];
        t_cfg_idx    all_regs[6];

        corner_l = '{12'h000, 12'hFFF, 12'h800, 12'h7FF, 12'hAAA, 12'h555, 12'hFFF, 12'h001};
        corner_r = '{12'hFFF, 12'h000, 12'h7FF, 12'h800, 12'h555, 12'hAAA, 12'hFFE, 12'h000};
        mid_regs = '{CFG_EXPECTED_REVS, CFG_DEAD_BAND, CFG_RUN_SPEED, CFG_CHECK_SPEED};
        all_regs = '{CFG_CALIBRATE_MS, CFG_VERIFY_MS, CFG_EXPECTED_REVS,
                     CFG_DEAD_BAND, CFG_RUN_SPEED, CFG_CHECK_SPEED};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Long windows so that the phase only moves on when the stimulus says so.
        write_reg(CFG_RUN_SPEED, 16'd127);
        write_reg(CFG_CHECK_SPEED, 16'd0);
        write_reg(CFG_CALIBRATE_MS, 16'hFFFF);
        write_reg(CFG_VERIFY_MS, 16'hFFFF);
        write_reg(CFG_EXPECTED_REVS, 16'd255);
        write_reg(CFG_DEAD_BAND, 16'hFFFF);
        cfg_idle();

        // The first tick starts calibration; the clock is about to wrap.
        now = 32'hFFFF_FFF8;
        l_centre = $urandom_range(4095);
        r_centre = $urandom_range(4095);
        l_spread = $urandom_range(1, 600);
        r_spread = $urandom_range(1, 600);
        send_tick(now, 12'h5A5, 12'hA5A, 8'd0, 8'd255);

        for (int i = 0; i < CAL_ITEMS; i++) begin
            if (i > 0 && i % 60 == 0) begin
                wait_drained();
                write_reg(mid_regs[$urandom_range(3)], reg_value(mid_regs[$urandom_range(3)]));
                cfg_idle();
            end
            now += $urandom_range(0, 3);
            send_tick(now, band_sample(l_centre, l_spread), band_sample(r_centre, r_spread),
                      8'($urandom()), 8'($urandom()));
        end

        // Close the sampling window, either at once or a few ms ahead.
        wait_drained();
        write_reg(CFG_DEAD_BAND, reg_value(CFG_DEAD_BAND));
        write_reg(CFG_CHECK_SPEED, reg_value(CFG_CHECK_SPEED));
        write_reg(CFG_CALIBRATE_MS, ($urandom_range(3) == 0) ? 16'd0 :
                  16'(32'(now - sb.start) + $urandom_range(1, 20)));
        write_reg(CFG_VERIFY_MS, RST_VERIFY_MS);
        cfg_idle();
        while (sb.phase == PH_CAL) begin
            now += $urandom_range(1, 3);
            send_tick(now, band_sample(l_centre, l_spread), band_sample(r_centre, r_spread),
                      8'($urandom()), 8'($urandom()));
        end

        // Sample extremes while verifying: the trackers must ignore them now.
        for (int i = 0; i < 8; i++) begin
            now += 1;
            send_tick(now, corner_l[i], corner_r[i], (i % 2) ? 8'd255 : 8'd0,
                      (i % 2) ? 8'd0 : 8'd255);
        end
        for (int i = 0; i < VERIFY_ITEMS; i++) begin
            if (i > 0 && i % 50 == 0) begin
                wait_drained();
                write_reg(CFG_RUN_SPEED, reg_value(CFG_RUN_SPEED));
                write_reg(CFG_EXPECTED_REVS, reg_value(CFG_EXPECTED_REVS));
                cfg_idle();
            end
            now += $urandom_range(0, 3);
            send_tick(now, 12'($urandom()), 12'($urandom()), 8'($urandom()), 8'($urandom()));
        end

        wait_drained();
        write_reg(CFG_EXPECTED_REVS, reg_value(CFG_EXPECTED_REVS));
        write_reg(CFG_RUN_SPEED, reg_value(CFG_RUN_SPEED));
        write_reg(CFG_VERIFY_MS, ($urandom_range(3) == 0) ? 16'd0 :
                  16'(32'(now - sb.start) + $urandom_range(1, 20)));
        cfg_idle();
        while (sb.phase == PH_VERIFY) begin
            now += $urandom_range(1, 3);
            lr = 8'($urandom());
            rr = 8'($urandom());
            case ($urandom_range(3))
                0, 1: begin
                    lr = sb.want_revs;
                    rr = sb.want_revs;
                end
                2: lr = sb.want_revs;
                default: rr = sb.want_revs;
            endcase
            send_tick(now, 12'($urandom()), 12'($urandom()), lr, rr);
        end

        // Calibrated or failed: every further tick only reports the phase.
        for (int i = 0; i < LATCHED_ITEMS; i++) begin
            if (i > 0 && i % 70 == 0) begin
                wait_drained();
                write_reg(all_regs[$urandom_range(5)], reg_value(all_regs[$urandom_range(5)]));
                cfg_idle();
            end
            send_tick($urandom(), 12'($urandom()), 12'($urandom()), 8'($urandom()),
                      8'($urandom()));
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report("result beats still outstanding at the end");
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
hdl/etc_pkg.sv
hdl/etc_bounds.sv
hdl/encoder_threshold_calibrator_core.sv
dv/testbench.sv
